>>> src/hief_pkg.sv
package hief_pkg;

	// Byte positions inside the configuration descriptor header.
	localparam logic [15:0] HDR_POS_LENGTH   = 16'd0;
	localparam logic [15:0] HDR_POS_TYPE     = 16'd1;
	localparam logic [15:0] HDR_POS_TOTAL_LO = 16'd2;
	localparam logic [15:0] HDR_POS_TOTAL_HI = 16'd3;

	// Byte offsets inside one length/type record.
	localparam logic [15:0] REC_OFF_LENGTH = 16'd0;
	localparam logic [15:0] REC_OFF_TYPE   = 16'd1;
	localparam logic [15:0] REC_OFF_BYTE2  = 16'd2;
	localparam logic [15:0] REC_OFF_BYTE3  = 16'd3;
	localparam logic [15:0] REC_OFF_BYTE4  = 16'd4;
	localparam logic [15:0] REC_OFF_BYTE5  = 16'd5;

	localparam logic [15:0] POS_MAX             = 16'hFFFF;
	localparam logic [7:0]  HEADER_MIN_LEN      = 8'd4;
	localparam logic [7:0]  MIN_RECORD_LEN      = 8'd2;
	localparam logic [7:0]  IFACE_DESC_LEN      = 8'd9;
	localparam logic [7:0]  EP_DESC_LEN         = 8'd7;
	localparam logic [7:0]  DESC_TYPE_INTERFACE = 8'h04;
	localparam logic [7:0]  DESC_TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0]  HID_CLASS_CODE      = 8'h03;
	localparam logic [1:0]  XFER_INTERRUPT      = 2'd3;

	typedef enum logic [1:0] {
		OUTCOME_FOUND     = 2'd0,
		OUTCOME_NOT_FOUND = 2'd1,
		OUTCOME_MALFORMED = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_set;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [7:0]  interface_number;
		logic [7:0]  alternate_setting;
		logic [7:0]  endpoint_address;
		logic [10:0] max_packet_size;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t result;
	} walk_out_t;

endpackage

>>> src/hief_in_stage.sv
module hief_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte [7:0]
	input  logic               s_tlast,   // last_byte
	input  logic               s_tuser,   // start_of_set
	input  logic               advance,
	output logic               valid_s1,
	output hief_pkg::in_item_t item_s1
);

	logic valid_q;

	// The stage frees up when its byte moves into the walker in the same cycle.
	assign s_tready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte    <= s_tdata;
			item_s1.start_of_set <= s_tuser;
			item_s1.last_byte    <= s_tlast;
		end
	end

	assign valid_s1 = valid_q;

endmodule

>>> src/hief_walker.sv
module hief_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  hief_pkg::in_item_t  item,
	output hief_pkg::walk_out_t walk
);

	logic [15:0] pos_q, total_q, rec_start_q;
	logic [7:0]  hdr_len_q, rec_len_q, rec_type_q;
	logic        if_valid_q, decided_q;
	logic [7:0]  if_class_q, if_num_q, if_alt_q;
	logic [7:0]  pend_num_q, pend_alt_q, pend_class_q;
	logic [7:0]  ep_addr_q;
	logic [1:0]  ep_xfer_q;
	logic [10:0] ep_mps_q;

	// State as seen by this byte: a start of set restarts the walk.
	logic [15:0] cur_pos, cur_total, cur_rec_start;
	logic [7:0]  cur_hdr_len, cur_rec_len, cur_rec_type;
	logic        cur_if_valid, cur_decided;
	logic [7:0]  cur_if_class, cur_if_num, cur_if_alt;
	logic [7:0]  cur_pend_num, cur_pend_alt, cur_pend_class;
	logic [7:0]  cur_ep_addr;
	logic [1:0]  cur_ep_xfer;
	logic [10:0] cur_ep_mps;

	logic [15:0] nxt_pos, nxt_total, nxt_rec_start;
	logic [7:0]  nxt_hdr_len, nxt_rec_len, nxt_rec_type;
	logic        nxt_if_valid, nxt_decided;
	logic [7:0]  nxt_if_class, nxt_if_num, nxt_if_alt;
	logic [7:0]  nxt_pend_num, nxt_pend_alt, nxt_pend_class;
	logic [7:0]  nxt_ep_addr;
	logic [1:0]  nxt_ep_xfer;
	logic [10:0] nxt_ep_mps;

	logic [15:0] off;
	logic [15:0] total_new;
	logic [16:0] rec_end;
	logic        emit;
	logic        found;
	logic        malformed;
	hief_pkg::result_t result;

	always_comb begin
		if (item.start_of_set) begin
			cur_pos        = '0;
			cur_total      = '0;
			cur_rec_start  = '0;
			cur_hdr_len    = '0;
			cur_rec_len    = '0;
			cur_rec_type   = '0;
			cur_if_valid   = 1'b0;
			cur_decided    = 1'b0;
			cur_if_class   = '0;
			cur_if_num     = '0;
			cur_if_alt     = '0;
			cur_pend_num   = '0;
			cur_pend_alt   = '0;
			cur_pend_class = '0;
			cur_ep_addr    = '0;
			cur_ep_xfer    = '0;
			cur_ep_mps     = '0;
		end else begin
			cur_pos        = pos_q;
			cur_total      = total_q;
			cur_rec_start  = rec_start_q;
			cur_hdr_len    = hdr_len_q;
			cur_rec_len    = rec_len_q;
			cur_rec_type   = rec_type_q;
			cur_if_valid   = if_valid_q;
			cur_decided    = decided_q;
			cur_if_class   = if_class_q;
			cur_if_num     = if_num_q;
			cur_if_alt     = if_alt_q;
			cur_pend_num   = pend_num_q;
			cur_pend_alt   = pend_alt_q;
			cur_pend_class = pend_class_q;
			cur_ep_addr    = ep_addr_q;
			cur_ep_xfer    = ep_xfer_q;
			cur_ep_mps     = ep_mps_q;
		end
	end

	always_comb begin
		nxt_pos        = cur_pos;
		nxt_total      = cur_total;
		nxt_rec_start  = cur_rec_start;
		nxt_hdr_len    = cur_hdr_len;
		nxt_rec_len    = cur_rec_len;
		nxt_rec_type   = cur_rec_type;
		nxt_if_valid   = cur_if_valid;
		nxt_decided    = cur_decided;
		nxt_if_class   = cur_if_class;
		nxt_if_num     = cur_if_num;
		nxt_if_alt     = cur_if_alt;
		nxt_pend_num   = cur_pend_num;
		nxt_pend_alt   = cur_pend_alt;
		nxt_pend_class = cur_pend_class;
		nxt_ep_addr    = cur_ep_addr;
		nxt_ep_xfer    = cur_ep_xfer;
		nxt_ep_mps     = cur_ep_mps;

		off       = cur_pos - cur_rec_start;
		total_new = {item.data_byte, cur_total[7:0]};
		rec_end   = {1'b0, cur_rec_start} + {9'd0, cur_rec_len};
		emit      = 1'b0;
		found     = 1'b0;
		malformed = 1'b0;

		result.outcome           = hief_pkg::OUTCOME_NOT_FOUND;
		result.interface_number  = '0;
		result.alternate_setting = '0;
		result.endpoint_address  = '0;
		result.max_packet_size   = '0;

		if (!cur_decided) begin
			if (cur_pos == hief_pkg::HDR_POS_LENGTH) begin
				nxt_hdr_len = item.data_byte;
				if (item.data_byte < hief_pkg::HEADER_MIN_LEN) begin
					emit = 1'b1;
				end
			end else if (cur_pos == hief_pkg::HDR_POS_TYPE) begin
				nxt_hdr_len = cur_hdr_len;
			end else if (cur_pos == hief_pkg::HDR_POS_TOTAL_LO) begin
				nxt_total = {8'd0, item.data_byte};
			end else if (cur_pos == hief_pkg::HDR_POS_TOTAL_HI) begin
				nxt_total     = total_new;
				nxt_rec_start = {8'd0, cur_hdr_len};
				// The body must hold at least one record header.
				if ({1'b0, total_new} <
						({9'd0, cur_hdr_len} + {9'd0, hief_pkg::MIN_RECORD_LEN})) begin
					emit = 1'b1;
				end
			end else if (cur_pos >= cur_rec_start) begin
				if (off == hief_pkg::REC_OFF_LENGTH) begin
					nxt_rec_len = item.data_byte;
				end else begin
					if (off == hief_pkg::REC_OFF_TYPE) begin
						nxt_rec_type = item.data_byte;
						if (cur_rec_len < hief_pkg::MIN_RECORD_LEN ||
								rec_end > {1'b0, cur_total}) begin
							emit           = 1'b1;
							malformed      = 1'b1;
							result.outcome = hief_pkg::OUTCOME_MALFORMED;
						end
					end
					if (!malformed) begin
						case (off)
							hief_pkg::REC_OFF_BYTE2: begin
								nxt_pend_num = item.data_byte;
								nxt_ep_addr  = item.data_byte;
							end
							hief_pkg::REC_OFF_BYTE3: begin
								nxt_pend_alt = item.data_byte;
								nxt_ep_xfer  = item.data_byte[1:0];
							end
							hief_pkg::REC_OFF_BYTE4: begin
								nxt_ep_mps[7:0] = item.data_byte;
							end
							hief_pkg::REC_OFF_BYTE5: begin
								nxt_pend_class   = item.data_byte;
								nxt_ep_mps[10:8] = item.data_byte[2:0];
							end
							default: begin
								nxt_ep_mps = cur_ep_mps;
							end
						endcase

						// Last byte of a well-formed record.
						if (({1'b0, off} + 17'd1) == {9'd0, cur_rec_len}) begin
							if (nxt_rec_type == hief_pkg::DESC_TYPE_INTERFACE &&
									cur_rec_len >= hief_pkg::IFACE_DESC_LEN) begin
								nxt_if_valid = 1'b1;
								nxt_if_num   = nxt_pend_num;
								nxt_if_alt   = nxt_pend_alt;
								nxt_if_class = nxt_pend_class;
							end else if (nxt_rec_type == hief_pkg::DESC_TYPE_ENDPOINT &&
									cur_if_valid &&
									cur_rec_len >= hief_pkg::EP_DESC_LEN &&
									cur_if_class == hief_pkg::HID_CLASS_CODE &&
									nxt_ep_xfer == hief_pkg::XFER_INTERRUPT &&
									nxt_ep_addr[7]) begin
								found = 1'b1;
							end

							if (found) begin
								emit                     = 1'b1;
								result.outcome           = hief_pkg::OUTCOME_FOUND;
								result.interface_number  = cur_if_num;
								result.alternate_setting = cur_if_alt;
								result.endpoint_address  = nxt_ep_addr;
								result.max_packet_size   = nxt_ep_mps;
							end else begin
								nxt_rec_start = rec_end[15:0];
								// A record that passed the overrun check ends within the set.
								if (({1'b0, cur_total} - rec_end) <
										{9'd0, hief_pkg::MIN_RECORD_LEN}) begin
									emit = 1'b1;
								end
							end
						end
					end
				end
			end

			if (cur_pos != hief_pkg::POS_MAX) begin
				nxt_pos = cur_pos + 16'd1;
			end

			// An early end of input closes an undecided walk.
			if (item.last_byte) begin
				emit = 1'b1;
			end
			if (emit) begin
				nxt_decided = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			total_q      <= '0;
			rec_start_q  <= '0;
			hdr_len_q    <= '0;
			rec_len_q    <= '0;
			rec_type_q   <= '0;
			if_valid_q   <= 1'b0;
			decided_q    <= 1'b1;
			if_class_q   <= '0;
			if_num_q     <= '0;
			if_alt_q     <= '0;
			pend_num_q   <= '0;
			pend_alt_q   <= '0;
			pend_class_q <= '0;
			ep_addr_q    <= '0;
			ep_xfer_q    <= '0;
			ep_mps_q     <= '0;
		end else if (en) begin
			pos_q        <= nxt_pos;
			total_q      <= nxt_total;
			rec_start_q  <= nxt_rec_start;
			hdr_len_q    <= nxt_hdr_len;
			rec_len_q    <= nxt_rec_len;
			rec_type_q   <= nxt_rec_type;
			if_valid_q   <= nxt_if_valid;
			decided_q    <= nxt_decided;
			if_class_q   <= nxt_if_class;
			if_num_q     <= nxt_if_num;
			if_alt_q     <= nxt_if_alt;
			pend_num_q   <= nxt_pend_num;
			pend_alt_q   <= nxt_pend_alt;
			pend_class_q <= nxt_pend_class;
			ep_addr_q    <= nxt_ep_addr;
			ep_xfer_q    <= nxt_ep_xfer;
			ep_mps_q     <= nxt_ep_mps;
		end
	end

	assign walk.emit   = emit;
	assign walk.result = result;

	// Every decision leaves the walker idle.
	a_emit_decides: assert property (@(posedge clk) disable iff (!arst_n)
		en && emit |=> decided_q)
		else $error("walker emitted a result but did not go idle");

	// An idle walker stays silent until the next start of set.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		en && decided_q && !item.start_of_set |-> !emit)
		else $error("walker emitted a result while idle");

	// A match is always an IN endpoint.
	a_found_is_in: assert property (@(posedge clk) disable iff (!arst_n)
		en && emit && result.outcome == hief_pkg::OUTCOME_FOUND |-> result.endpoint_address[7])
		else $error("found endpoint is not an IN endpoint");

endmodule

>>> src/hief_out_stage.sv
module hief_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  hief_pkg::result_t   result,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // outcome [1:0], interface_number [9:2],
	                                       // alternate_setting [17:10],
	                                       // endpoint_address [25:18],
	                                       // max_packet_size [36:26], zero [39:37]
	output logic                free
);

	logic              valid_q;
	hief_pkg::result_t result_q;

	// A new result may be written when the register is empty or is being taken.
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'd0, result_q.max_packet_size, result_q.endpoint_address,
		result_q.alternate_setting, result_q.interface_number, result_q.outcome};

endmodule

>>> src/hid_interrupt_in_endpoint_finder.sv
// Finds the first interrupt IN endpoint of a HID interface in a USB configuration
// descriptor set that arrives one byte per transfer.
//
// Input channel (s_*): one descriptor byte per transfer in s_tdata. s_tuser marks the
// first byte of a set and restarts the walk; s_tlast marks the final supplied byte and
// closes an undecided walk with a not-found result.
// Output channel (m_*): at most one result per set, carrying the outcome (found, end
// without match, malformed record) with interface number, alternate setting, endpoint
// address and max packet size; the last four are zero unless found.
//
// The deciding byte passes from the input register through the walker into the result
// register, which drives m_tvalid. One byte is taken every cycle unless the receiver
// stalls: an input register feeds a walker that updates its record tracking state as
// each byte is taken, and the result register follows. When the receiver stalls with
// a result waiting, the walker holds; s_tready falls once the input register is full.
// After reset the block is idle: bytes are accepted and dropped until a start of set.
// Bytes after a decision are dropped the same way.
module hid_interrupt_in_endpoint_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte [7:0]
	input  logic        s_tlast,   // last_byte
	input  logic        s_tuser,   // start_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // outcome [1:0], interface_number [9:2],
	                               // alternate_setting [17:10], endpoint_address [25:18],
	                               // max_packet_size [36:26], zero [39:37]
);

	logic                valid_s1;
	hief_pkg::in_item_t  item_s1;
	hief_pkg::walk_out_t walk;
	logic                out_free;
	logic                advance;
	logic                walk_en;

	assign advance = out_free;
	assign walk_en = valid_s1 && advance;

	hief_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hief_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (walk_en),
		.item   (item_s1),
		.walk   (walk)
	);

	hief_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (walk_en && walk.emit),
		.result   (walk.result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.free     (out_free)
	);

endmodule
